// ===== rtl/lj_pkg.sv =====
// ============================================================================
// lj_pkg: shared types and constants for the LJ pair force pipeline
// Field widths, register codes, reset values and pipeline depths.
// ============================================================================
package lj_pkg;

    localparam int POS_W     = 32;   // Q8.24 coordinate
    localparam int CFG_W     = 32;   // configuration register width
    localparam int CFG_IDX_W = 3;    // eight registers
    localparam int OUT_W     = 48;   // Q24.24 result
    localparam int FRAC      = 24;   // fraction bits of the internal Q.24 values
    localparam int DIV_Q_W   = 56;   // quotient of (value << 24) / r2
    localparam int DIV_D_W   = 32;   // divisor width (r2 inside cutoff)
    localparam int MUL_W     = 64;   // operand width of the scaled multiplier
    localparam int MUL_STAGES = 3;   // partial products, sum, shift and clamp

    // fold, square, select, divide, three chained products, difference,
    // two parallel products, force products, output register
    localparam int LATENCY = 3 + DIV_Q_W + 3 * MUL_STAGES + 1 + 2 * MUL_STAGES + 1;

    localparam logic [MUL_W-1:0] PROD_CAP   = 64'h1000_0000_0000_0000;
    localparam logic [OUT_W-1:0] OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [MUL_W-1:0] OUT_NEG_MAG = 64'h0000_8000_0000_0000;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_LENGTH     = 3'd0,
        CFG_CUTOFF_SQ      = 3'd1,
        CFG_SIGMA_SQ_AA    = 3'd2,
        CFG_SIGMA_SQ_XX    = 3'd3,
        CFG_SIGMA_SQ_MIXED = 3'd4,
        CFG_EPS_AA         = 3'd5,
        CFG_EPS_XX         = 3'd6,
        CFG_EPS_MIXED      = 3'd7
    } t_cfg_reg;

    localparam logic [CFG_W-1:0] RST_BOX_LENGTH     = 32'd646761677;
    localparam logic [CFG_W-1:0] RST_CUTOFF_SQ      = 32'd6735073;
    localparam logic [CFG_W-1:0] RST_SIGMA_SQ_AA    = 32'd504671;
    localparam logic [CFG_W-1:0] RST_SIGMA_SQ_XX    = 32'd1077600;
    localparam logic [CFG_W-1:0] RST_SIGMA_SQ_MIXED = 32'd764295;
    localparam logic [CFG_W-1:0] RST_EPS_AA         = 32'd2413756;
    localparam logic [CFG_W-1:0] RST_EPS_XX         = 32'd14298644;
    localparam logic [CFG_W-1:0] RST_EPS_MIXED      = 32'd5874844;

    // sideband from the select stage to the difference stage
    typedef struct packed {
        logic                      valid;
        logic                      in_cut;
        logic [2:0]                dneg;
        logic [2:0][POS_W-1:0]     mag;
        logic [CFG_W-1:0]          eps;
    } t_side_a;

    // sideband from the difference stage to the force products
    typedef struct packed {
        logic                      valid;
        logic                      in_cut;
        logic [2:0]                dneg;
        logic [2:0][POS_W-1:0]     mag;
        logic                      tneg;
        logic                      eneg;
    } t_side_b;

    // sideband from the force products to the output register
    typedef struct packed {
        logic                      valid;
        logic                      in_cut;
        logic [2:0]                dneg;
        logic                      tneg;
        logic                      eneg;
    } t_side_c;

endpackage

// ===== rtl/lj_delay.sv =====
// ============================================================================
// lj_delay: fixed-depth shift line
// Delays a bus through DEPTH register taps; reset clears every tap.
// ============================================================================
module lj_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // shift one tap per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_tap[k] <= '0;
            end
        end else begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// ===== rtl/lj_div.sv =====
// ============================================================================
// lj_div: pipelined restoring divider
// One quotient bit per stage, N stages, a new division every cycle.
// ============================================================================
module lj_div #(
    parameter int N = lj_pkg::DIV_Q_W,
    parameter int W = lj_pkg::DIV_D_W
) (
    input  logic         i_clk,
    input  logic [N-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [N-1:0] o_quotient
);

    logic [W-1:0] r_rem [N];
    logic [N-1:0] r_quo [N];
    logic [N-1:0] r_dvd [N];
    logic [W-1:0] r_dsr [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [W-1:0] rem_in;
        logic [N-1:0] quo_in;
        logic [N-1:0] dvd_in;
        logic [W-1:0] dsr_in;
        logic [W:0]   trial;
        logic         ge;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign dvd_in = i_dividend;
            assign dsr_in = i_divisor;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign quo_in = r_quo[g-1];
            assign dvd_in = r_dvd[g-1];
            assign dsr_in = r_dsr[g-1];
        end

        // bring down the next dividend bit and try the subtraction
        assign trial = {rem_in, dvd_in[N-1]};
        assign ge    = trial >= {1'b0, dsr_in};

        always_ff @(posedge i_clk) begin
            r_rem[g] <= ge ? W'(trial - {1'b0, dsr_in}) : trial[W-1:0];
            r_quo[g] <= {quo_in[N-2:0], ge};
            r_dvd[g] <= {dvd_in[N-2:0], 1'b0};
            r_dsr[g] <= dsr_in;
        end
    end

    assign o_quotient = r_quo[N-1];

endmodule

// ===== rtl/lj_mul.sv =====
// ============================================================================
// lj_mul: scaled 64x64 multiplier
// Returns min(floor(a*b / 2^SHIFT), 2^60) in three stages: four 32x32
// partial products, their sum, then shift and clamp.
// ============================================================================
module lj_mul #(
    parameter int SHIFT = lj_pkg::FRAC
) (
    input  logic                     i_clk,
    input  logic [lj_pkg::MUL_W-1:0] i_a,
    input  logic [lj_pkg::MUL_W-1:0] i_b,
    output logic [lj_pkg::MUL_W-1:0] o_p
);

    localparam int HW = lj_pkg::MUL_W / 2;
    localparam int FW = 2 * lj_pkg::MUL_W;

    logic [lj_pkg::MUL_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [FW-1:0]            r_full;
    logic [lj_pkg::MUL_W-1:0] r_out;
    logic [FW-1:0]            shifted;

    // partial products
    always_ff @(posedge i_clk) begin
        r_p0 <= i_a[HW-1:0]  * i_b[HW-1:0];
        r_p1 <= i_a[HW-1:0]  * i_b[2*HW-1:HW];
        r_p2 <= i_a[2*HW-1:HW] * i_b[HW-1:0];
        r_p3 <= i_a[2*HW-1:HW] * i_b[2*HW-1:HW];
    end

    // combine partial products
    always_ff @(posedge i_clk) begin
        r_full <= {r_p3, {lj_pkg::MUL_W{1'b0}}}
                + (FW'(r_p1) << HW) + (FW'(r_p2) << HW) + FW'(r_p0);
    end

    // scale and clamp
    assign shifted = r_full >> SHIFT;

    always_ff @(posedge i_clk) begin
        r_out <= (shifted > FW'(lj_pkg::PROD_CAP)) ? lj_pkg::PROD_CAP
                                                   : shifted[lj_pkg::MUL_W-1:0];
    end

    assign o_p = r_out;

endmodule

// ===== rtl/lj_pair_force_top.sv =====
// ============================================================================
// lj_pair_force_top: Lennard-Jones 12-6 pair force with minimum image
// Folds the pair separation, forms r2, divides and multiplies through a
// fixed-latency pipeline and returns the force components and pair energy.
// ============================================================================
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  pair in  | start, busy               | i_first_*, i_second_*, i_*_species
//  result   | o_strobe (one cycle)      | o_force_*, o_pair_energy,
//           |                           | o_within_cutoff
//  config   | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
//  One pair per cycle; the depth from each transfer to its result is set
//  by the 56-stage radix-2 divider and five chained multiplies.
//  busy stays low: the pipeline never stalls and the receiver cannot stall.
//  Reset (synchronous, active low) empties the pipeline and loads the
//  register defaults.
//
module lj_pair_force_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lj_pkg::POS_W-1:0]    i_first_x,
    input  logic [lj_pkg::POS_W-1:0]    i_first_y,
    input  logic [lj_pkg::POS_W-1:0]    i_first_z,
    input  logic [lj_pkg::POS_W-1:0]    i_second_x,
    input  logic [lj_pkg::POS_W-1:0]    i_second_y,
    input  logic [lj_pkg::POS_W-1:0]    i_second_z,
    input  logic                        i_first_species,
    input  logic                        i_second_species,
    input  logic                        i_cfg_wr_en,
    input  logic [lj_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lj_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                        o_strobe,
    output logic signed [lj_pkg::OUT_W-1:0] o_force_x,
    output logic signed [lj_pkg::OUT_W-1:0] o_force_y,
    output logic signed [lj_pkg::OUT_W-1:0] o_force_z,
    output logic signed [lj_pkg::OUT_W-1:0] o_pair_energy,
    output logic                        o_within_cutoff
);

    localparam int PW = lj_pkg::POS_W;
    localparam int CW = lj_pkg::CFG_W;
    localparam int MW = lj_pkg::MUL_W;
    localparam int OW = lj_pkg::OUT_W;
    localparam int QW = lj_pkg::DIV_Q_W;
    localparam int MS = lj_pkg::MUL_STAGES;

    // ---------------- configuration registers ----------------
    logic [CW-1:0] r_box_length, r_cutoff_sq;
    logic [CW-1:0] r_sig_aa, r_sig_xx, r_sig_mixed;
    logic [CW-1:0] r_eps_aa, r_eps_xx, r_eps_mixed;

    // load a register on a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_length <= lj_pkg::RST_BOX_LENGTH;
            r_cutoff_sq  <= lj_pkg::RST_CUTOFF_SQ;
            r_sig_aa     <= lj_pkg::RST_SIGMA_SQ_AA;
            r_sig_xx     <= lj_pkg::RST_SIGMA_SQ_XX;
            r_sig_mixed  <= lj_pkg::RST_SIGMA_SQ_MIXED;
            r_eps_aa     <= lj_pkg::RST_EPS_AA;
            r_eps_xx     <= lj_pkg::RST_EPS_XX;
            r_eps_mixed  <= lj_pkg::RST_EPS_MIXED;
        end else if (i_cfg_wr_en) begin
            unique case (lj_pkg::t_cfg_reg'(i_cfg_index))
                lj_pkg::CFG_BOX_LENGTH:     r_box_length <= i_cfg_data;
                lj_pkg::CFG_CUTOFF_SQ:      r_cutoff_sq  <= i_cfg_data;
                lj_pkg::CFG_SIGMA_SQ_AA:    r_sig_aa     <= i_cfg_data;
                lj_pkg::CFG_SIGMA_SQ_XX:    r_sig_xx     <= i_cfg_data;
                lj_pkg::CFG_SIGMA_SQ_MIXED: r_sig_mixed  <= i_cfg_data;
                lj_pkg::CFG_EPS_AA:         r_eps_aa     <= i_cfg_data;
                lj_pkg::CFG_EPS_XX:         r_eps_xx     <= i_cfg_data;
                lj_pkg::CFG_EPS_MIXED:      r_eps_mixed  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage 1: minimum-image fold ----------------
    function automatic logic [PW:0] fold_axis(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b,
                                              input logic [PW-1:0] len);
        logic signed [PW+1:0] d;
        logic signed [PW+2:0] twice;
        logic signed [PW+2:0] slen;
        logic signed [PW+1:0] res;
        logic [PW+1:0]        mag;
        d     = $signed({2'b00, a}) - $signed({2'b00, b});
        twice = {d, 1'b0};
        slen  = $signed({3'b000, len});
        res   = d;
        if (twice >= slen) begin
            res = d - $signed({2'b00, len});
        end else if (twice <= -slen) begin
            res = d + $signed({2'b00, len});
        end
        mag = res[PW+1] ? (PW+2)'(-res) : res;
        return {res[PW+1], mag[PW-1:0]};
    endfunction

    logic          r_s1_valid;
    logic [2:0]    r_s1_dneg;
    logic [PW-1:0] r_s1_mag [3];
    logic          r_s1_sa, r_s1_sb;
    logic [PW:0]   fx, fy, fz;

    assign fx = fold_axis(i_first_x, i_second_x, r_box_length);
    assign fy = fold_axis(i_first_y, i_second_y, r_box_length);
    assign fz = fold_axis(i_first_z, i_second_z, r_box_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dneg   <= {fz[PW], fy[PW], fx[PW]};
        r_s1_mag[0] <= fx[PW-1:0];
        r_s1_mag[1] <= fy[PW-1:0];
        r_s1_mag[2] <= fz[PW-1:0];
        r_s1_sa     <= i_first_species;
        r_s1_sb     <= i_second_species;
    end

    // ---------------- stage 2: squares ----------------
    logic          r_s2_valid;
    logic [2:0]    r_s2_dneg;
    logic [PW-1:0] r_s2_mag [3];
    logic [2*PW-1:0] r_s2_sq [3];
    logic          r_s2_sa, r_s2_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_s2_sq[k]  <= r_s1_mag[k] * r_s1_mag[k];
            r_s2_mag[k] <= r_s1_mag[k];
        end
        r_s2_dneg <= r_s1_dneg;
        r_s2_sa   <= r_s1_sa;
        r_s2_sb   <= r_s1_sb;
    end

    // ---------------- stage 3: r2, cutoff test, species select ----------------
    logic [2*PW+1:0] sum_sq;
    logic [PW+1:0]   r2;
    logic [CW-1:0]   sel_sig, sel_eps;

    assign sum_sq = (2*PW+2)'(r_s2_sq[0]) + (2*PW+2)'(r_s2_sq[1])
                  + (2*PW+2)'(r_s2_sq[2]);
    assign r2     = sum_sq[2*PW+1:PW];

    always_comb begin
        unique case ({r_s2_sa, r_s2_sb})
            2'b00: begin
                sel_sig = r_sig_aa;
                sel_eps = r_eps_aa;
            end
            2'b11: begin
                sel_sig = r_sig_xx;
                sel_eps = r_eps_xx;
            end
            2'b01, 2'b10: begin
                sel_sig = r_sig_mixed;
                sel_eps = r_eps_mixed;
            end
        endcase
    end

    logic          r_s3_valid;
    logic          r_s3_within;
    logic [2:0]    r_s3_dneg;
    logic [PW-1:0] r_s3_mag [3];
    logic [CW-1:0] r_s3_sig, r_s3_eps;
    logic [lj_pkg::DIV_D_W-1:0] r_s3_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    // coincident atoms divide by one LSB
    always_ff @(posedge i_clk) begin
        r_s3_within <= r2 < {2'b00, r_cutoff_sq};
        r_s3_dneg   <= r_s2_dneg;
        r_s3_mag    <= r_s2_mag;
        r_s3_sig    <= sel_sig;
        r_s3_eps    <= sel_eps;
        r_s3_div    <= (r2 == '0) ? lj_pkg::DIV_D_W'(1) : r2[lj_pkg::DIV_D_W-1:0];
    end

    // ---------------- dividers: q = sig2/r2, w = eps/r2 (Q.24) ----------------
    logic [QW-1:0] div_q, div_w;

    lj_div #(.N(QW), .W(lj_pkg::DIV_D_W)) u_div_q (
        .i_clk      (i_clk),
        .i_dividend ({r_s3_sig, {lj_pkg::FRAC{1'b0}}}),
        .i_divisor  (r_s3_div),
        .o_quotient (div_q)
    );

    lj_div #(.N(QW), .W(lj_pkg::DIV_D_W)) u_div_w (
        .i_clk      (i_clk),
        .i_dividend ({r_s3_eps, {lj_pkg::FRAC{1'b0}}}),
        .i_divisor  (r_s3_div),
        .o_quotient (div_w)
    );

    // carry the sideband across the divider and the power chain
    lj_pkg::t_side_a side_a_in, side_a_out;

    always_comb begin
        side_a_in.valid  = r_s3_valid;
        side_a_in.in_cut = r_s3_within;
        side_a_in.dneg   = r_s3_dneg;
        for (int k = 0; k < 3; k++) begin
            side_a_in.mag[k] = r_s3_mag[k];
        end
        side_a_in.eps    = r_s3_eps;
    end

    lj_delay #(.WIDTH($bits(lj_pkg::t_side_a)), .DEPTH(QW + 3 * MS)) u_dly_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (side_a_in),
        .o_data  (side_a_out)
    );

    // ---------------- power chain: s6 = q^3, s12 = s6^2 ----------------
    logic [MW-1:0] q_ext, q2, q_dly, s6, s6_dly, s12, w_dly;

    assign q_ext = MW'(div_q);

    lj_mul #(.SHIFT(lj_pkg::FRAC)) u_mul_q2 (
        .i_clk (i_clk), .i_a (q_ext), .i_b (q_ext), .o_p (q2)
    );

    lj_delay #(.WIDTH(MW), .DEPTH(MS)) u_dly_q (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (q_ext), .o_data (q_dly)
    );

    lj_mul #(.SHIFT(lj_pkg::FRAC)) u_mul_s6 (
        .i_clk (i_clk), .i_a (q2), .i_b (q_dly), .o_p (s6)
    );

    lj_mul #(.SHIFT(lj_pkg::FRAC)) u_mul_s12 (
        .i_clk (i_clk), .i_a (s6), .i_b (s6), .o_p (s12)
    );

    lj_delay #(.WIDTH(MW), .DEPTH(MS)) u_dly_s6 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (s6), .o_data (s6_dly)
    );

    lj_delay #(.WIDTH(MW), .DEPTH(3 * MS)) u_dly_w (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (MW'(div_w)), .o_data (w_dly)
    );

    // ---------------- difference stage ----------------
    logic signed [MW+1:0] e_diff, t_val;

    assign e_diff = $signed({2'b00, s12}) - $signed({2'b00, s6_dly});
    assign t_val  = $signed({1'b0, s12, 1'b0}) - $signed({2'b00, s6_dly});

    logic          r_d_valid, r_d_within, r_d_tneg, r_d_eneg;
    logic [2:0]    r_d_dneg;
    logic [2:0][PW-1:0] r_d_mag;
    logic [MW-1:0] r_d_emag, r_d_tmag, r_d_eps4, r_d_w24;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= side_a_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_within <= side_a_out.in_cut;
        r_d_dneg   <= side_a_out.dneg;
        r_d_mag    <= side_a_out.mag;
        r_d_eneg   <= e_diff[MW+1];
        r_d_tneg   <= t_val[MW+1];
        r_d_emag   <= e_diff[MW+1] ? MW'(-e_diff) : MW'(e_diff);
        r_d_tmag   <= t_val[MW+1] ? MW'(-t_val) : MW'(t_val);
        r_d_eps4   <= {{(MW-CW-2){1'b0}}, side_a_out.eps, 2'b00};
        r_d_w24    <= (w_dly << 4) + (w_dly << 3);
    end

    // ---------------- energy and force-over-r products ----------------
    logic [MW-1:0] emag, fr, emag_dly;

    lj_mul #(.SHIFT(16)) u_mul_energy (
        .i_clk (i_clk), .i_a (r_d_eps4), .i_b (r_d_emag), .o_p (emag)
    );

    lj_mul #(.SHIFT(lj_pkg::FRAC)) u_mul_fr (
        .i_clk (i_clk), .i_a (r_d_w24), .i_b (r_d_tmag), .o_p (fr)
    );

    lj_pkg::t_side_b side_b_in, side_b_out;

    assign side_b_in = '{valid: r_d_valid, in_cut: r_d_within, dneg: r_d_dneg,
                         mag: r_d_mag, tneg: r_d_tneg, eneg: r_d_eneg};

    lj_delay #(.WIDTH($bits(lj_pkg::t_side_b)), .DEPTH(MS)) u_dly_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (side_b_in), .o_data (side_b_out)
    );

    // ---------------- force components ----------------
    logic [MW-1:0] fmag [3];

    for (genvar k = 0; k < 3; k++) begin : g_force
        lj_mul #(.SHIFT(lj_pkg::FRAC)) u_mul_force (
            .i_clk (i_clk),
            .i_a   (fr),
            .i_b   (MW'(side_b_out.mag[k])),
            .o_p   (fmag[k])
        );
    end

    lj_pkg::t_side_c side_c_in, side_c_out;

    assign side_c_in = '{valid: side_b_out.valid, in_cut: side_b_out.in_cut,
                         dneg: side_b_out.dneg, tneg: side_b_out.tneg,
                         eneg: side_b_out.eneg};

    lj_delay #(.WIDTH($bits(lj_pkg::t_side_c)), .DEPTH(MS)) u_dly_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (side_c_in), .o_data (side_c_out)
    );

    lj_delay #(.WIDTH(MW), .DEPTH(MS)) u_dly_e (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_data (emag), .o_data (emag_dly)
    );

    // ---------------- output saturation and register ----------------
    function automatic logic [OW-1:0] sat48(input logic [MW-1:0] mag, input logic neg);
        logic [MW-1:0] m;
        if (!neg) begin
            return (mag > MW'(lj_pkg::OUT_POS_MAX)) ? lj_pkg::OUT_POS_MAX : mag[OW-1:0];
        end
        m = (mag > lj_pkg::OUT_NEG_MAG) ? lj_pkg::OUT_NEG_MAG : mag;
        return OW'(-m);
    endfunction

    logic out_live;
    logic [OW-1:0] n_fx, n_fy, n_fz, n_en;

    assign out_live = side_c_out.valid && side_c_out.in_cut;
    assign n_fx = out_live ? sat48(fmag[0], side_c_out.tneg ^ side_c_out.dneg[0]) : '0;
    assign n_fy = out_live ? sat48(fmag[1], side_c_out.tneg ^ side_c_out.dneg[1]) : '0;
    assign n_fz = out_live ? sat48(fmag[2], side_c_out.tneg ^ side_c_out.dneg[2]) : '0;
    assign n_en = out_live ? sat48(emag_dly, side_c_out.eneg) : '0;

    logic r_strobe, r_within;
    logic [OW-1:0] r_fx, r_fy, r_fz, r_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_within <= 1'b0;
        end else begin
            r_strobe <= side_c_out.valid;
            r_within <= out_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fx <= n_fx;
        r_fy <= n_fy;
        r_fz <= n_fz;
        r_en <= n_en;
    end

    assign o_strobe        = r_strobe;
    assign o_within_cutoff = r_within;
    assign o_force_x       = $signed(r_fx);
    assign o_force_y       = $signed(r_fy);
    assign o_force_z       = $signed(r_fz);
    assign o_pair_energy   = $signed(r_en);

endmodule

// ===== rtl/lj_pair_force_chk.sv =====
// ============================================================================
// lj_pair_force_chk: port-level checks for the pair force pipeline
// Fixed latency, flag qualification and zeroed results outside cutoff.
// ============================================================================
module lj_pair_force_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic signed [lj_pkg::OUT_W-1:0] o_force_x,
    input logic signed [lj_pkg::OUT_W-1:0] o_force_y,
    input logic signed [lj_pkg::OUT_W-1:0] o_force_z,
    input logic signed [lj_pkg::OUT_W-1:0] o_pair_energy,
    input logic                        o_within_cutoff
);

    // every transfer yields a result after the pipeline depth
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(lj_pkg::LATENCY) o_strobe)
        else $error("result missing after pair transfer");

    // no result without a matching transfer
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##(lj_pkg::LATENCY) !o_strobe)
        else $error("result without pair transfer");

    // flag only marks a delivered result
    a_flag_qualified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_within_cutoff |-> o_strobe)
        else $error("within_cutoff without strobe");

    // out-of-cutoff results are zero
    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_within_cutoff) |->
        (o_force_x == '0 && o_force_y == '0 && o_force_z == '0 && o_pair_energy == '0))
        else $error("nonzero result outside cutoff");

endmodule

bind lj_pair_force_top lj_pair_force_chk u_chk (.*);
